[hw/rtl/bb3_pkg.sv]
// Shared types, constants and the reciprocal table for the 3x3 RGB box blur.
package bb3_pkg;

  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int HEIGHT_W   = 12;
  localparam int ROW_W      = 13;  // input row runs to height + 1 while draining
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SUM_W      = 12;  // 9 * 255 fits
  localparam int CNT_W      = 4;
  localparam int NUM_W      = 13;  // 2 * sum + count
  localparam int RECIP_W    = 17;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W     = NUM_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } pix_out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // request taken, launch line-store read
    logic shift;   // shift window, update line stores and input position
    logic sum;     // form neighborhood sums, advance output position
    logic load;    // divide and load the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;      // flush before the frame is complete: no effect
    logic emit;      // this request produces a result
    logic out_free;  // output register can take a result this cycle
  } ctrl_sts_t;

  // ceil(2^17 / (2 * count)); exact for numerators below 4600
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/bb3_if.sv]
// Request channel interfaces for pixel input and blurred pixel output.
interface bb3_in_if;
  import bb3_pkg::*;
  logic    valid;
  logic    ready;
  pix_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bb3_out_if;
  import bb3_pkg::*;
  logic     valid;
  logic     ready;
  pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/bb3_datapath.sv]
// Line stores, window, position counters, sum and reciprocal divide for the box blur.
module bb3_datapath #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
  input  bb3_pkg::pix_in_t              in_data,
  input  bb3_pkg::ctrl_cmd_t            cmd,
  output bb3_pkg::ctrl_sts_t            sts,
  output bb3_pkg::pix_out_t             out_data,
  output logic                          out_valid,
  input  logic                          out_ready
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (EW > CFG_W) ? EW : CFG_W;

  logic [CFG_W-1:0]    width_reg;
  logic [CFG_W-1:0]    height_reg;
  logic [EW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [XW-1:0]       width_x;

  logic [CW-1:0]       in_col;
  logic [ROW_W-1:0]    in_row;
  logic [CW-1:0]       out_col;
  logic [HEIGHT_W-1:0] out_row;

  logic                item_flush;
  logic [PIX_W-1:0]    item_px;
  logic [PIX_W-1:0]    px_eff;

  logic [PIX_W-1:0]    upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0]    lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0]    rd_upper;
  logic [PIX_W-1:0]    rd_lower;
  logic [PIX_W-1:0]    win [3][3];  // [row][col], col 2 newest

  logic                draining;
  logic                in_wrap;
  logic                last_now;
  logic                out_wrap;
  logic                restart;
  logic [2:0]          row_ok;
  logic [2:0]          col_ok;

  logic [SUM_W-1:0]    row_sum [3][3];  // [row][channel]
  logic [CNT_W-1:0]    row_cnt [3];
  logic [SUM_W-1:0]    sum_next [3];
  logic [CNT_W-1:0]    cnt_next;
  logic [SUM_W-1:0]    sum_q [3];
  logic [CNT_W-1:0]    cnt_q;
  logic                last_q;

  logic [NUM_W-1:0]    num [3];
  logic [PROD_W-1:0]   prod [3];
  logic [RECIP_W-1:0]  rcp;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_reg  <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_x = XW'(width_reg);
    if (width_x == '0) begin
      w_eff = EW'(1);
    end else if (width_x > XW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_x);
    end
    h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
  end

  // status
  assign draining = in_row >= ROW_W'(h_eff);
  assign px_eff   = draining ? '0 : item_px;
  assign in_wrap  = (EW'(in_col) + EW'(1)) >= w_eff;
  assign out_wrap = (EW'(out_col) + EW'(1)) >= w_eff;
  assign last_now = ((out_row + HEIGHT_W'(1)) >= h_eff) && out_wrap;
  assign restart  = cfg_we || (cmd.sum && last_now);

  assign sts.skip     = (item_flush == OP_FLUSH) && !draining;
  assign sts.emit     = (in_row > ROW_W'(1)) || (in_row == ROW_W'(1) && in_col != '0);
  assign sts.out_free = !out_valid || out_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_flush <= in_data.opcode;
      item_px    <= {in_data.red, in_data.green, in_data.blue};
    end
  end

  // line stores: read on accept, write back on shift, same column
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_upper <= upper_mem[in_col];
      rd_lower <= lower_mem[in_col];
    end
    if (cmd.shift) begin
      upper_mem[in_col] <= rd_lower;
      lower_mem[in_col] <= px_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win[r][k] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_upper;
      win[1][2] <= rd_lower;
      win[2][2] <= px_eff;
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (cmd.shift) begin
        if (in_wrap) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (cmd.sum) begin
        if (out_wrap) begin
          out_col <= '0;
          out_row <= out_row + HEIGHT_W'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // masked neighborhood sums, row by row
  always_comb begin
    row_ok[0] = out_row != '0;
    row_ok[1] = 1'b1;
    row_ok[2] = (out_row + HEIGHT_W'(1)) < h_eff;
    col_ok[0] = out_col != '0;
    col_ok[1] = 1'b1;
    col_ok[2] = !out_wrap;
    for (int r = 0; r < 3; r++) begin
      row_cnt[r] = '0;
      for (int ch = 0; ch < 3; ch++) begin
        row_sum[r][ch] = '0;
      end
      for (int k = 0; k < 3; k++) begin
        if (row_ok[r] && col_ok[k]) begin
          row_cnt[r] = row_cnt[r] + CNT_W'(1);
          for (int ch = 0; ch < 3; ch++) begin
            row_sum[r][ch] = row_sum[r][ch]
                             + SUM_W'(win[r][k][(2 - ch) * CH_W +: CH_W]);
          end
        end
      end
    end
    cnt_next = row_cnt[0] + row_cnt[1] + row_cnt[2];
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = row_sum[0][ch] + row_sum[1][ch] + row_sum[2][ch];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= sum_next[ch];
      end
      cnt_q  <= cnt_next;
      last_q <= last_now;
    end
  end

  // round half up: (2*sum + count) * ceil(2^17 / (2*count)) >> 17
  always_comb begin
    rcp = recip(cnt_q);
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = {sum_q[ch], 1'b0} + NUM_W'(cnt_q);
      prod[ch] = PROD_W'(num[ch]) * PROD_W'(rcp);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.red_out   <= prod[0][RECIP_SHIFT +: CH_W];
      out_data.green_out <= prod[1][RECIP_SHIFT +: CH_W];
      out_data.blue_out  <= prod[2][RECIP_SHIFT +: CH_W];
      out_data.frame_end <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    EW'(in_col) < w_eff)
    else $error("input column beyond frame width");

  a_out_behind_in: assert property (@(posedge clk) disable iff (rst)
    ROW_W'(out_row) <= in_row)
    else $error("output row ahead of input row");

  a_sum_after_shift: assert property (@(posedge clk) disable iff (rst)
    cmd.sum |-> $past(cmd.shift))
    else $error("sum step without preceding window shift");

endmodule

[hw/rtl/bb3_ctrl.sv]
// Sequencer for the box blur: accept, shift, sum, divide/load.
module bb3_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bb3_pkg::ctrl_sts_t sts,
  output bb3_pkg::ctrl_cmd_t cmd
);
  import bb3_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_SUM   = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready   = state == S_IDLE;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.shift  = (state == S_SHIFT) && !sts.skip;
  assign cmd.sum    = state == S_SUM;
  assign cmd.load   = (state == S_DIV) && sts.out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (!sts.skip && sts.emit) state_next = S_SUM;
        else state_next = S_IDLE;
      end
      S_SUM: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/box_blur_3x3_rgb_top.sv]
// Top level of the 3x3 RGB box blur: request channels, configuration port, controller, datapath.
//
// Pixels of one frame arrive in raster order on pix_in (opcode 0). Each result is
// the per-channel average over the 3x3 neighborhood of one pixel, counting only
// neighbors inside the frame, rounded half up. Results trail the input by one row
// plus one pixel; after the frame's last pixel the source sends image_width + 1
// flush requests (opcode 1) to drain the rest, and the last result carries
// frame_end. A flush before the last pixel is dropped with no result; a pixel sent
// during the drain counts as a flush. Each request goes through four steps: one to
// accept it and read both line stores (single-port, registered read), one to shift
// the window and write the stores back, one to form the masked sums, one to divide
// by the neighbor count through a reciprocal multiply and load the output register;
// a request with no result ends after the shift. The output register lets the next
// request in while a result waits, but the divide step stalls while it is still full.
// Register writes (index 0 width, index 1 height) restart the frame and must be made
// only while the block is idle (not enforced). Line stores are not cleared; no reset pass.
module box_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
  bb3_in_if.sink                        pix_in,
  bb3_out_if.source                     pix_out
);
  import bb3_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (pix_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bb3_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (pix_in.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (pix_out.data),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready)
  );

endmodule

[dv/box_blur_3x3_rgb_top_tb.sv]
// Self-checking testbench for the 3x3 RGB box blur: predicted frames, random gaps and stalls.
module box_blur_3x3_rgb_top_tb;
  import bb3_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int MAX_WAIT      = 14;    // longest sender gap / receiver stall per request
  localparam int SETTLE_CYCLES = 20;
  localparam int STUCK_LIMIT   = 1000;  // cycles with no request moving on any port
  localparam int RAND_ITEMS    = 650;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bb3_in_if  in_ch ();
  bb3_out_if out_ch ();

  box_blur_3x3_rgb_top #(.MAX_WIDTH(MAX_W)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (in_ch),
    .pix_out   (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Blur predictor: its own copy of registers, line stores, window and the
  // input/output raster positions.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] blur_width;
  logic [CFG_W-1:0] blur_height;
  logic [PIX_W-1:0] two_rows_up [MAX_W];
  logic [PIX_W-1:0] one_row_up  [MAX_W];
  logic [PIX_W-1:0] win [3][3];  // [row][col], col 2 newest
  int in_col, in_row, out_col, out_row;

  // width 0 behaves as 1, anything past the line-store depth as the depth
  function automatic int eff_w();
    if (blur_width == '0) return 1;
    if (blur_width > MAX_W) return MAX_W;
    return int'(blur_width);
  endfunction

  function automatic int eff_h();
    return (blur_height == '0) ? 1 : int'(blur_height);
  endfunction

  function automatic void restart_raster();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // One accepted request in, at most one blurred pixel out.
  function automatic bit blur_predict(input pix_in_t req, output pix_out_t res);
    int w, h, c, cnt;
    int acc [3];
    bit draining, emit, is_last;
    logic [PIX_W-1:0] px, v;
    w = eff_w();
    h = eff_h();
    res = '0;
    draining = (in_row >= h);
    // flush before the last pixel of the frame: dropped outright
    if (req.opcode == OP_FLUSH && !draining) return 1'b0;
    // a pixel during the drain is taken as a flush, data thrown away
    px = draining ? '0 : {req.red, req.green, req.blue};
    c = (in_col >= MAX_W) ? MAX_W - 1 : in_col;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = two_rows_up[c];
    win[1][2] = one_row_up[c];
    win[2][2] = px;
    two_rows_up[c] = one_row_up[c];
    one_row_up[c]  = px;
    emit = (in_row > 1) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return 1'b0;
    acc = '{0, 0, 0};
    cnt = 0;
    // neighbors outside the frame are masked off
    for (int r = 0; r < 3; r++) begin
      if (r == 0 && out_row == 0) continue;
      if (r == 2 && out_row + 1 >= h) continue;
      for (int k = 0; k < 3; k++) begin
        if (k == 0 && out_col == 0) continue;
        if (k == 2 && out_col + 1 >= w) continue;
        v = win[r][k];
        acc[0] += v[23:16];
        acc[1] += v[15:8];
        acc[2] += v[7:0];
        cnt++;
      end
    end
    is_last = (out_row + 1 >= h) && (out_col + 1 >= w);
    // round half up, all integer
    res.red_out   = CH_W'((2 * acc[0] + cnt) / (2 * cnt));
    res.green_out = CH_W'((2 * acc[1] + cnt) / (2 * cnt));
    res.blue_out  = CH_W'((2 * acc[2] + cnt) / (2 * cnt));
    res.frame_end = is_last;
    if (is_last) begin
      restart_raster();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  pix_in_t  pixel_q [$];    // requests waiting for the driver
  pix_out_t blurred_q [$];  // blurred pixels still owed by the block
  int errors, n_requests, n_results, n_setups, rand_items;
  int stuck;
  bit in_fire, out_fire;
  bit sender_lazy, receiver_lazy;  // 0 = no idling on that side this frame
  int send_wait, recv_wait, recv_next;
  pix_out_t got, want, predicted;

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes on the falling edge, holds a request until taken.
  // The gap drawn with a request is spent after it is accepted.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_wait   <= 0;
    end else if (!in_ch.valid || in_fire) begin
      if (send_wait != 0) begin
        in_ch.valid <= 1'b0;
        send_wait   <= send_wait - 1;
      end else if (pixel_q.size() != 0) begin
        in_ch.data  <= pixel_q.pop_front();
        in_ch.valid <= 1'b1;
        send_wait   <= sender_lazy ? $urandom_range(0, MAX_WAIT) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side: after each taken result, ready drops for a drawn stall.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_wait    <= 0;
    end else begin
      recv_next = out_fire ? (receiver_lazy ? $urandom_range(0, MAX_WAIT) : 0) : recv_wait;
      if (recv_next != 0) begin
        out_ch.ready <= 1'b0;
        recv_wait    <= recv_next - 1;
      end else begin
        out_ch.ready <= 1'b1;
        recv_wait    <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled on the rising edge. Results are checked first;
  // a result can never belong to a request taken on the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire  <= !rst && in_ch.valid && in_ch.ready;
    out_fire <= !rst && out_ch.valid && out_ch.ready;
    if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;

    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      got = out_ch.data;
      if (blurred_q.size() == 0) begin
        note_error($sformatf("unexpected result r=%0d g=%0d b=%0d end=%0d",
                             got.red_out, got.green_out, got.blue_out, got.frame_end));
      end else begin
        want = blurred_q.pop_front();
        if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
            got.blue_out !== want.blue_out || got.frame_end !== want.frame_end)
          note_error($sformatf("result %0d: exp %0d/%0d/%0d end %0d, got %0d/%0d/%0d end %0d",
                               n_results, want.red_out, want.green_out, want.blue_out,
                               want.frame_end, got.red_out, got.green_out, got.blue_out,
                               got.frame_end));
      end
    end

    if (!rst && in_ch.valid && in_ch.ready) begin
      n_requests++;
      if (blur_predict(in_ch.data, predicted)) blurred_q.push_back(predicted);
    end
  end

  // Watchdog: nothing moving for too long means a hang.
  initial begin : watchdog
    stuck = 0;
    while (stuck < STUCK_LIMIT) @(posedge clk);
    $display("TIMEOUT: no request moved for %0d cycles, %0d results owed",
             STUCK_LIMIT, blurred_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_req(input logic op, input logic [CH_W-1:0] r,
                                   input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    pix_in_t item;
    item.opcode = op;
    item.red    = r;
    item.green  = g;
    item.blue   = b;
    pixel_q.push_back(item);
  endfunction

  // npix random pixels, then ndrain drain requests. With noise, stray flushes
  // land inside the frame and some drain requests carry pixel data.
  function automatic void push_frame(input int npix, input int ndrain, input bit noisy);
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) push_req(OP_FLUSH, rand_chan(), rand_chan(),
                                                        rand_chan());
      push_req(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
    end
    for (int j = 0; j < ndrain; j++) begin
      if (noisy && $urandom_range(0, 3) == 0)
        push_req(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      else
        push_req(OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
    end
    rand_items += npix + ndrain;
  endfunction

  // Wait until every queued request is taken and every result has come back,
  // then give requests that make no result time to leave the pipeline.
  task automatic settle();
    while (pixel_q.size() != 0 || in_ch.valid || blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write while idle; the predictor takes it at the same point.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_WIDTH) blur_width = val;
    else                  blur_height = val;
    restart_raster();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h);
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    n_setups++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int w, h, npix;
    bit broken;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    errors = 0; n_requests = 0; n_results = 0; n_setups = 0; rand_items = 0;
    in_fire = 1'b0; out_fire = 1'b0;
    sender_lazy = 1'b1; receiver_lazy = 1'b1;
    send_wait = 0; recv_wait = 0;
    blur_width  = WIDTH_RESET;
    blur_height = HEIGHT_RESET;
    for (int i = 0; i < MAX_W; i++) begin
      two_rows_up[i] = '0;
      one_row_up[i]  = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) win[r][k] = '0;
    restart_raster();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Largest register values, cut short: no result may appear in row 0.
    set_frame(4095, 4095);
    push_frame(100, 0, 1'b0);
    settle();

    // Narrow and tall frame.
    set_frame(2, 150);
    push_frame(300, 3, 1'b0);
    settle();

    // Directed: 3x3 with channel extremes, a flush ahead of the frame and a
    // pixel inside the drain.
    set_frame(3, 3);
    push_req(OP_FLUSH, 8'hff, 8'hff, 8'hff);
    push_req(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    push_req(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    push_req(OP_PIXEL, 8'hff, 8'h00, 8'hff);
    push_req(OP_PIXEL, 8'h00, 8'hff, 8'h00);
    push_req(OP_PIXEL, 8'haa, 8'h55, 8'haa);
    push_req(OP_PIXEL, 8'h55, 8'haa, 8'h55);
    push_req(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    push_req(OP_PIXEL, 8'h01, 8'h80, 8'hfe);
    push_req(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    push_req(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    push_req(OP_PIXEL, 8'h12, 8'h34, 8'h56);
    push_req(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    push_req(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    settle();
    // single-pixel frame: count of one
    set_frame(1, 1);
    push_req(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    push_req(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    push_req(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    settle();
    // zero width and height behave as one
    set_frame(0, 0);
    push_req(OP_PIXEL, 8'h80, 8'h7f, 8'h01);
    push_req(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    push_req(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    settle();

    // Random frames, mostly small. Every frame starts with a register write, so
    // a broken (cut-short) frame is abandoned cleanly by the next one.
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      sender_lazy   = ($urandom_range(0, 3) != 0);
      receiver_lazy = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0:          w = 0;
        1, 2, 3, 4: w = $urandom_range(9, 40);
        default:    w = $urandom_range(1, 8);
      endcase
      write_reg(REG_WIDTH, CFG_W'(w));
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 15))
          0:       h = 0;
          1, 2, 3: h = $urandom_range(7, 12);
          default: h = $urandom_range(1, 6);
        endcase
        write_reg(REG_HEIGHT, CFG_W'(h));
      end
      n_setups++;
      npix   = eff_w() * eff_h();
      broken = ($urandom_range(0, 4) == 0);
      if (broken)
        push_frame($urandom_range(0, npix - 1), 0, 1'b1);
      else
        push_frame(npix, eff_w() + 1, $urandom_range(0, 1));
      settle();
    end

    sender_lazy   = 1'b1;
    receiver_lazy = 1'b1;
    settle();
    if (blurred_q.size() != 0)
      note_error($sformatf("%0d blurred pixels never arrived", blurred_q.size()));
    $display("Ran %0d frame setups: %0d requests, %0d results checked, %0d errors.",
             n_setups, n_requests, n_results, errors);
    $display("Frames 1x1 to 40x12, zero and oversized sizes, flush noise, cut frames, stalls.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
